// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

// ===== src/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg
// Types and constants for the interval room allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int FIELD_W   = 7;

	localparam logic FUNC_END   = 1'b0;
	localparam logic FUNC_START = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_ROOM = 2'd1,
		STATUS_BAD_ID  = 2'd2,
		STATUS_NOT_RUN = 2'd3
	} status_t;

	typedef struct packed {
		logic               func;
		logic [FIELD_W-1:0] activity_id;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] room;
		logic [FIELD_W-1:0] rooms_in_use;
		logic [FIELD_W-1:0] peak_rooms;
		status_t            status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // request accepted: latch it, launch memory reads
		logic commit;   // update state, load result register
	} cmd_t;

endpackage

`default_nettype wire

// ===== src/interval_room_allocator.sv =====
// ----------------------------------------------------------------------------
// interval_room_allocator
// Greedy room allocation over time-sorted activity start/end events.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one event: func (1 = start, 0 = end) and
//   activity_id. rsp (valid/ready) returns one result per event: the room
//   taken or freed, rooms in use, peak so far and a status code.
//   cfg_we/cfg_wdata write the activity count (0 acts as 1, above 64 as 64)
//   and restart the allocator: all rooms free, room 1 on top, peak cleared.
//   Write the count only while no request is in flight.
// Timing:
//   A request first reads the free-room stack and the room table
//   (registered-read memories), then updates state and loads the result
//   register. One request is in flight at a time: the next is taken only
//   once the last has loaded the result register. The result is valid
//   after that load. A new request is taken while an earlier result waits
//   in the result register; if rsp_ready stays low, the next request holds
//   in its execute cycle until the result register drains.
// Reset:
//   arst_n clears the sequencer and restores a count of 64 with all rooms
//   free; no clearing pass is needed (untouched stack slots are implied).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module interval_room_allocator import ira_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_t                    rsp,
	input  wire logic               cfg_we,
	input  wire logic [FIELD_W-1:0] cfg_wdata
);

	cmd_t cmd;

	ira_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	ira_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

	`ASSERT_IMPL(a_err_no_room, clk, arst_n, rsp_valid && (rsp.status != STATUS_OK), rsp.room == '0)
	`ASSERT_IMPL(a_peak_covers, clk, arst_n, rsp_valid, rsp.rooms_in_use <= rsp.peak_rooms)
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)
	`ASSERT_NEXT(a_result_follows, clk, arst_n, cmd.commit, rsp_valid)

endmodule

`default_nettype wire

// ===== src/ira_ram.sv =====
// ----------------------------------------------------------------------------
// ira_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ira_ctrl.sv =====
// ----------------------------------------------------------------------------
// ira_ctrl
// Controller: request/result handshakes and the two-state sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ctrl import ira_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		cmd.capture = req_valid && req_ready;
		// result register must be free (or draining this cycle)
		cmd.commit  = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ===== src/ira_datapath.sv =====
// ----------------------------------------------------------------------------
// ira_datapath
// Free-room stack, room table, running flags, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_datapath import ira_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire req_t               req,
	input  wire logic               cfg_we,
	input  wire logic [FIELD_W-1:0] cfg_wdata,
	output rsp_t                    rsp
);

	logic [CNT_W-1:0]     count_q;      // effective activity count
	logic [CNT_W-1:0]     depth_q;      // free-room stack depth
	logic [CNT_W-1:0]     low_mark_q;   // lowest depth since restart
	logic [FIELD_W-1:0]   peak_q;
	logic [MAX_ITEMS-1:0] running_q;
	req_t                 req_q;
	rsp_t                 rsp_q;

	logic [FIELD_W-1:0] stack_rdata, table_rdata;
	logic [CNT_W-1:0]   cfg_count;
	logic [CNT_W-1:0]   top_slot;
	logic [IDX_W-1:0]   req_idx, cur_idx;

	logic               id_ok, run;
	logic [FIELD_W-1:0] top_room;
	logic [CNT_W-1:0]   depth_d;
	logic [FIELD_W-1:0] in_use, peak_d;
	rsp_t               rsp_d;
	logic               do_pop, do_push;

	// clamp written count into 1..MAX_ITEMS
	always_comb begin
		cfg_count = CNT_W'(cfg_wdata);
		if (cfg_wdata == '0) begin
			cfg_count = CNT_W'(1);
		end else if (CNT_W'(cfg_wdata) > CNT_W'(MAX_ITEMS)) begin
			cfg_count = CNT_W'(MAX_ITEMS);
		end
	end

	assign top_slot = depth_q - CNT_W'(1);
	assign req_idx  = IDX_W'(req.activity_id - FIELD_W'(1));
	assign cur_idx  = IDX_W'(req_q.activity_id - FIELD_W'(1));

	ira_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_ITEMS)) u_stack (
		.clk   (clk),
		.we    (cmd.commit && do_push),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (table_rdata),
		.re    (cmd.capture),
		.raddr (top_slot[IDX_W-1:0]),
		.rdata (stack_rdata)
	);

	ira_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_ITEMS)) u_room_table (
		.clk   (clk),
		.we    (cmd.commit && do_pop),
		.waddr (cur_idx),
		.wdata (top_room),
		.re    (cmd.capture),
		.raddr (req_idx),
		.rdata (table_rdata)
	);

	always_comb begin
		id_ok = (req_q.activity_id != '0) && (CNT_W'(req_q.activity_id) <= count_q);
		run   = running_q[cur_idx];
		// slots below the low mark are not written since restart: their room is count - slot
		if (top_slot < low_mark_q) begin
			top_room = FIELD_W'(count_q - top_slot);
		end else begin
			top_room = stack_rdata;
		end

		do_pop       = 1'b0;
		do_push      = 1'b0;
		depth_d      = depth_q;
		rsp_d.room   = '0;
		rsp_d.status = STATUS_OK;

		if (!id_ok) begin
			rsp_d.status = STATUS_BAD_ID;
		end else if (req_q.func == FUNC_START) begin
			if (run) begin
				rsp_d.room = table_rdata;
			end else if (depth_q == '0) begin
				rsp_d.status = STATUS_NO_ROOM;
			end else begin
				do_pop     = 1'b1;
				depth_d    = top_slot;
				rsp_d.room = top_room;
			end
		end else begin
			if (!run) begin
				rsp_d.status = STATUS_NOT_RUN;
			end else begin
				do_push    = 1'b1;
				depth_d    = depth_q + CNT_W'(1);
				rsp_d.room = table_rdata;
			end
		end

		in_use = (count_q >= depth_d) ? FIELD_W'(count_q - depth_d) : '0;
		peak_d = (in_use > peak_q) ? in_use : peak_q;

		rsp_d.rooms_in_use = in_use;
		rsp_d.peak_rooms   = peak_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CNT_W'(MAX_ITEMS);
			depth_q    <= CNT_W'(MAX_ITEMS);
			low_mark_q <= CNT_W'(MAX_ITEMS);
			peak_q     <= '0;
			running_q  <= '0;
		end else if (cfg_we) begin
			count_q    <= cfg_count;
			depth_q    <= cfg_count;
			low_mark_q <= cfg_count;
			peak_q     <= '0;
			running_q  <= '0;
		end else if (cmd.commit) begin
			depth_q <= depth_d;
			peak_q  <= peak_d;
			if (do_pop) begin
				running_q[cur_idx] <= 1'b1;
				if (depth_d < low_mark_q) begin
					low_mark_q <= depth_d;
				end
			end
			if (do_push) begin
				running_q[cur_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== tb/tb_interval_room_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_room_allocator
// Self-checking bench for the room allocator. A model of the free-room
// stack and the room table predicts every response. Directed cases
// come first, then random phases under several activity counts.
// Both handshakes get random idle bursts.
// ----------------------------------------------------------------------------

module tb_interval_room_allocator;
	import ira_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 48;
	localparam int PHASES      = 11;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_ready;
	rsp_t               rsp;
	logic               cfg_we;
	logic [FIELD_W-1:0] cfg_wdata;

	interval_room_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// allocator model state
	logic [FIELD_W-1:0] free_rooms [MAX_ITEMS];
	int                 free_depth;
	logic [FIELD_W-1:0] room_of [MAX_ITEMS+1];
	bit                 running [MAX_ITEMS+1];
	int                 peak_in_use;
	int                 room_total;

	rsp_t room_results_due [$];
	int   error_count = 0;
	int   cycle_count = 0;
	int   idle_pct = 0;

	// stimulus-side view of which activities hold a room
	int   gen_rooms;
	bit   gen_live [MAX_ITEMS+1];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_count(logic [FIELD_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_ITEMS)
			return MAX_ITEMS;
		return c;
	endfunction

	function automatic void restart_allocator_model(logic [FIELD_W-1:0] c);
		int i;
		room_total = clamp_count(c);
		for (i = 0; i < MAX_ITEMS; i++)
			free_rooms[i] = (i < room_total) ? FIELD_W'(room_total - i) : '0;
		free_depth = room_total;
		for (i = 0; i <= MAX_ITEMS; i++) begin
			running[i] = 1'b0;
			room_of[i] = '0;
		end
		peak_in_use = 0;
	endfunction

	function automatic rsp_t predict_allocation(req_t r);
		rsp_t res;
		int   id;
		int   in_use;
		id = r.activity_id;
		res.room = '0;
		res.status = STATUS_OK;
		if (id < 1 || id > room_total) begin
			res.status = STATUS_BAD_ID;
		end else if (r.func == FUNC_START) begin
			if (running[id]) begin
				res.room = room_of[id];
			end else if (free_depth == 0) begin
				res.status = STATUS_NO_ROOM;
			end else begin
				free_depth--;
				res.room = free_rooms[free_depth];
				room_of[id] = res.room;
				running[id] = 1'b1;
			end
		end else begin
			if (!running[id]) begin
				res.status = STATUS_NOT_RUN;
			end else begin
				res.room = room_of[id];
				if (free_depth < MAX_ITEMS) begin
					free_rooms[free_depth] = res.room;
					free_depth++;
				end
				running[id] = 1'b0;
			end
		end
		in_use = (room_total >= free_depth) ? room_total - free_depth : 0;
		if (in_use > peak_in_use)
			peak_in_use = in_use;
		res.rooms_in_use = FIELD_W'(in_use);
		res.peak_rooms = FIELD_W'(peak_in_use);
		return res;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// response check, request prediction and config tracking, all at the edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (room_results_due.size() == 0) begin
					report_error("response with no request outstanding");
				end else begin
					want = room_results_due.pop_front();
					if (rsp.room !== want.room)
						report_error($sformatf("room got %0d want %0d",
							rsp.room, want.room));
					if (rsp.rooms_in_use !== want.rooms_in_use)
						report_error($sformatf("rooms_in_use got %0d want %0d",
							rsp.rooms_in_use, want.rooms_in_use));
					if (rsp.peak_rooms !== want.peak_rooms)
						report_error($sformatf("peak_rooms got %0d want %0d",
							rsp.peak_rooms, want.peak_rooms));
					if (rsp.status !== want.status)
						report_error($sformatf("status got %0d want %0d",
							rsp.status, want.status));
				end
			end
			if (req_valid && req_ready)
				room_results_due.push_back(predict_allocation(req));
			if (cfg_we)
				restart_allocator_model(cfg_wdata);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// response side back-pressure
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	// valid stays high after the accept; the caller's next step decides
	task automatic send_event(logic func, int id);
		req_t item;
		item.func = func;
		item.activity_id = FIELD_W'(id);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (id >= 1 && id <= gen_rooms)
			gen_live[id] = (func == FUNC_START);
	endtask

	task automatic settle_allocator();
		req_valid <= 1'b0;
		@(posedge clk);
		while (room_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(logic [FIELD_W-1:0] value);
		int i;
		settle_allocator();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_rooms = clamp_count(value);
		for (i = 0; i <= MAX_ITEMS; i++)
			gen_live[i] = 1'b0;
	endtask

	// random id in range with the wanted live state, 0 if none
	function automatic int pick_id(bit want_live);
		int first;
		int id;
		int k;
		first = $urandom_range(0, gen_rooms - 1);
		for (k = 0; k < gen_rooms; k++) begin
			id = 1 + (first + k) % gen_rooms;
			if (gen_live[id] == want_live)
				return id;
		end
		return 0;
	endfunction

	// reset count of 64, stack order, repeats and error codes
	task automatic test_basic_allocation();
		send_event(FUNC_START, 1);    // room 1 first
		send_event(FUNC_START, 2);
		send_event(FUNC_START, 1);    // already running: same room again
		send_event(FUNC_END, 3);      // never started
		send_event(FUNC_START, 0);
		send_event(FUNC_START, 64);
		send_event(FUNC_START, 65);
		send_event(FUNC_END, 127);
		send_event(FUNC_END, 2);
		send_event(FUNC_START, 5);    // reuses room 2 from the top
		send_event(FUNC_END, 1);
		send_event(FUNC_END, 5);
		send_event(FUNC_END, 64);
		send_event(FUNC_END, 64);
	endtask

	// zero acts as one room, anything above the max acts as the max
	task automatic test_count_limits();
		write_count(7'd0);
		send_event(FUNC_START, 1);
		send_event(FUNC_START, 2);
		send_event(FUNC_START, 1);
		send_event(FUNC_END, 1);
		send_event(FUNC_END, 1);
		write_count(7'd127);
		send_event(FUNC_START, 64);
		send_event(FUNC_START, 65);
		send_event(FUNC_END, 64);
	endtask

	// mostly legal schedules with random order of ends, some noise
	task automatic test_random_schedule();
		int  plan [PHASES-1];
		int  p;
		int  n;
		int  id;
		int  start_pct;
		bit  want_start;
		plan = '{64, 1, 2, 5, 17, 127, 0, 33, 90, 64};
		for (p = 0; p < PHASES; p++) begin
			write_count((p < PHASES - 1) ? FIELD_W'(plan[p])
				: FIELD_W'($urandom_range(0, 127)));
			if (p == PHASES - 1)
				idle_pct = 0;
			else if ($urandom_range(0, 3) == 0)
				idle_pct = 0;
			else
				idle_pct = $urandom_range(5, 30);
			start_pct = $urandom_range(45, 75);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					want_start = ($urandom_range(0, 99) < start_pct);
					id = pick_id(!want_start);
					if (id == 0) begin
						want_start = !want_start;
						id = pick_id(!want_start);
					end
					send_event(want_start ? FUNC_START : FUNC_END, id);
				end else begin
					id = $urandom_range(0, 1) ? $urandom_range(0, 127)
						: $urandom_range(0, gen_rooms + 1);
					send_event($urandom_range(0, 1) ? FUNC_START : FUNC_END, id);
				end
			end
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 10;
		restart_allocator_model(FIELD_W'(MAX_ITEMS));
		gen_rooms = MAX_ITEMS;
		for (i = 0; i <= MAX_ITEMS; i++)
			gen_live[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_allocation();
		test_count_limits();
		test_random_schedule();
		settle_allocator();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/ira_pkg.sv
src/ira_ram.sv
src/ira_ctrl.sv
src/ira_datapath.sv
src/interval_room_allocator.sv
tb/tb_interval_room_allocator.sv
